@@ hw/rtl/sos_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_pkg
// Shared types, constants and the pattern lookup for the SOS Morse beacon.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam int PatternLen = 18;
  localparam int ElemIdxW   = 5;
  localparam int PosW       = 7;
  localparam int PrescW     = 4;
  localparam int CountW     = 32;
  localparam int BattW      = 7;
  localparam int ToneW      = 16;

  localparam logic [BattW-1:0]  BatteryFull    = 7'd100;
  localparam logic [ToneW-1:0]  ToneReset      = 16'd1500;
  localparam logic [PrescW-1:0] TicksPerSecond = 4'd10;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef logic [PosW-1:0] elem_end_t [PatternLen];

  // Last tick position of each element: dots 2, dashes 6, gaps 2/6/14.
  localparam elem_end_t ElemEnd = '{
    7'd2,  7'd4,  7'd6,  7'd8,  7'd10, 7'd16,
    7'd22, 7'd24, 7'd30, 7'd32, 7'd38, 7'd44,
    7'd46, 7'd48, 7'd50, 7'd52, 7'd54, 7'd68
  };

  typedef struct packed {
    logic                found;
    logic [ElemIdxW-1:0] idx;
  } lookup_t;

  typedef struct packed {
    logic              light_on;
    logic [ToneW-1:0]  tone_hz;
    logic [ElemIdxW-1:0] element_index;
    logic [CountW-1:0] elapsed_seconds;
    logic [CountW-1:0] cycle_count;
    logic              active;
    logic              radio_beacons_on;
    logic [BattW-1:0]  battery_status;
  } res_t;

  // First element whose end is at or past pos; independent compares.
  function automatic lookup_t elem_lookup(input logic [PosW-1:0] pos);
    lookup_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = PatternLen - 1; i >= 0; i--) begin
      if (pos <= ElemEnd[i]) begin
        r.found = 1'b1;
        r.idx   = ElemIdxW'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/sos_morse_beacon_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_morse_beacon_sequencer_top
// SOS Morse beacon sequencer stepped by 100 ms tick words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation word:
//   tick, start, stop or init, plus the battery level used on active ticks.
//   Output channel (out_valid_o / out_stall_i) returns one status word per
//   input word: light, tone, element, seconds, cycles, flags and battery.
//   A word is taken on a rising edge with valid high and stall low.
//   The result word is registered into the result register, or into the skid register while the receiver stalls.
//   Throughput: one word per cycle while in_stall_o is low; the state update is a single pass of
//   compare logic between the state registers and the result register.
//   A two-entry output stage (result register plus skid register) lets one
//   input word be taken while a result is held by a stalling receiver;
//   in_stall_o rises only when both entries are full.
//   cfg_we_i / cfg_wdata_i write the tone frequency; write only while idle.
//   Reset: all beacon state cleared, battery 100, tone 1500 Hz, no output.
// ----------------------------------------------------------------------------
module sos_morse_beacon_sequencer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sos_pkg::ToneW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [sos_pkg::BattW-1:0]         battery_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              light_on_o,
  output logic [sos_pkg::ToneW-1:0]         tone_hz_o,
  output logic [sos_pkg::ElemIdxW-1:0]      element_index_o,
  output logic [sos_pkg::CountW-1:0]        elapsed_seconds_o,
  output logic [sos_pkg::CountW-1:0]        cycle_count_o,
  output logic                              active_o,
  output logic                              radio_beacons_on_o,
  output logic [sos_pkg::BattW-1:0]         battery_status_o
);

  logic [sos_pkg::ToneW-1:0]    tone_q;
  logic                         running_q, running_d;
  logic [sos_pkg::PosW-1:0]     pos_q, pos_d;
  logic [sos_pkg::ElemIdxW-1:0] elem_q, elem_d;
  logic                         lamp_q, lamp_d;
  logic [sos_pkg::PrescW-1:0]   presc_q, presc_d;
  logic [sos_pkg::CountW-1:0]   secs_q, secs_d;
  logic [sos_pkg::CountW-1:0]   cycles_q, cycles_d;
  logic [sos_pkg::BattW-1:0]    batt_q, batt_d;
  logic                         radios_q, radios_d;

  logic                         in_accept;
  logic [sos_pkg::PosW-1:0]     pos_inc;
  logic [sos_pkg::PrescW-1:0]   presc_inc;
  sos_pkg::lookup_t             lk;
  sos_pkg::op_e                 op;
  sos_pkg::res_t                res_d, out_q, skid_q;
  logic                         out_vld_q, skid_vld_q, out_ready;
  logic                         light;

  assign op         = sos_pkg::op_e'(operation_i);
  assign in_stall_o = skid_vld_q;
  assign in_accept  = in_valid_i && !skid_vld_q;
  assign pos_inc    = pos_q + sos_pkg::PosW'(1);
  assign presc_inc  = presc_q + sos_pkg::PrescW'(1);
  assign lk         = sos_pkg::elem_lookup(pos_inc);

  always_comb begin
    running_d = running_q;
    pos_d     = pos_q;
    elem_d    = elem_q;
    lamp_d    = lamp_q;
    presc_d   = presc_q;
    secs_d    = secs_q;
    cycles_d  = cycles_q;
    batt_d    = batt_q;
    radios_d  = radios_q;
    case (op)
      sos_pkg::OP_TICK: begin
        if (running_q) begin
          batt_d = (battery_level_i > sos_pkg::BatteryFull) ? sos_pkg::BatteryFull
                                                            : battery_level_i;
          if (presc_inc >= sos_pkg::TicksPerSecond) begin
            presc_d = '0;
            secs_d  = secs_q + sos_pkg::CountW'(1);
          end else begin
            presc_d = presc_inc;
          end
          if (lk.found) begin
            pos_d  = pos_inc;
            elem_d = lk.idx;
            lamp_d = ~lk.idx[0];  // even elements are marks
          end else begin
            // past the last gap: wrap into the first dot
            pos_d    = sos_pkg::PosW'(1);
            elem_d   = '0;
            lamp_d   = 1'b1;
            cycles_d = cycles_q + sos_pkg::CountW'(1);
          end
        end
      end
      sos_pkg::OP_START: begin
        running_d = 1'b1;
        radios_d  = 1'b1;
        pos_d     = '0;
        elem_d    = '0;
        lamp_d    = 1'b0;
        presc_d   = '0;
        secs_d    = '0;
        cycles_d  = '0;
      end
      sos_pkg::OP_STOP: begin
        running_d = 1'b0;
        lamp_d    = 1'b0;
        radios_d  = 1'b0;
        pos_d     = '0;
        presc_d   = '0;
      end
      default: begin
        running_d = 1'b0;
        pos_d     = '0;
        elem_d    = '0;
        lamp_d    = 1'b0;
        presc_d   = '0;
        secs_d    = '0;
        cycles_d  = '0;
        batt_d    = sos_pkg::BatteryFull;
        radios_d  = 1'b0;
      end
    endcase
  end

  assign light = running_d && lamp_d;

  always_comb begin
    res_d.light_on         = light;
    res_d.tone_hz          = light ? tone_q : '0;
    res_d.element_index    = elem_d;
    res_d.elapsed_seconds  = secs_d;
    res_d.cycle_count      = cycles_d;
    res_d.active           = running_d;
    res_d.radio_beacons_on = radios_d;
    res_d.battery_status   = batt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_q    <= sos_pkg::ToneReset;
      running_q <= 1'b0;
      pos_q     <= '0;
      elem_q    <= '0;
      lamp_q    <= 1'b0;
      presc_q   <= '0;
      secs_q    <= '0;
      cycles_q  <= '0;
      batt_q    <= sos_pkg::BatteryFull;
      radios_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tone_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        running_q <= running_d;
        pos_q     <= pos_d;
        elem_q    <= elem_d;
        lamp_q    <= lamp_d;
        presc_q   <= presc_d;
        secs_q    <= secs_d;
        cycles_q  <= cycles_d;
        batt_q    <= batt_d;
        radios_q  <= radios_d;
      end
    end
  end

  // output register plus skid entry
  assign out_ready = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_ready) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= in_accept;
        end
      end else if (in_accept) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= res_d;
      end
    end else if (in_accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign light_on_o         = out_q.light_on;
  assign tone_hz_o          = out_q.tone_hz;
  assign element_index_o    = out_q.element_index;
  assign elapsed_seconds_o  = out_q.elapsed_seconds;
  assign cycle_count_o      = out_q.cycle_count;
  assign active_o           = out_q.active;
  assign radio_beacons_on_o = out_q.radio_beacons_on;
  assign battery_status_o   = out_q.battery_status;

`ifndef ASSERT_OFF
  // skid entry only fills behind a held result word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without output word");

  a_light_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && light_on_o) |-> active_o)
    else $error("light on while beacon inactive");

  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_q <= sos_pkg::ElemIdxW'(sos_pkg::PatternLen - 1))
    else $error("element index out of range");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= sos_pkg::ElemEnd[sos_pkg::PatternLen-1]) &&
    (presc_q < sos_pkg::TicksPerSecond))
    else $error("pattern position or prescaler out of range");
`endif

endmodule

@@ test/sos_morse_beacon_sequencer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_morse_beacon_sequencer_top_tb
// Self-checking bench for the SOS beacon sequencer: a scoreboard class
// predicts every status word from the operation words it has seen, while
// random gaps and stall bursts are applied on both channels.
// ----------------------------------------------------------------------------

class beacon_scoreboard;
  // Beacon state, kept at the block's widths.
  logic                           running;
  logic [sos_pkg::PosW-1:0]       position;
  logic [sos_pkg::ElemIdxW-1:0]   element;
  logic                           lamp;
  logic [sos_pkg::PrescW-1:0]     tenths;
  logic [sos_pkg::CountW-1:0]     seconds;
  logic [sos_pkg::CountW-1:0]     cycles;
  logic [sos_pkg::BattW-1:0]      battery;
  logic                           radios;
  logic [sos_pkg::ToneW-1:0]      tone;

  int unsigned                    ticks_of [sos_pkg::PatternLen];
  sos_pkg::res_t                  status_due [$];
  int                             failures;

  function new();
    // dot, gap, dot, gap, dot, letter gap, dash ... word gap at the end
    ticks_of = '{2, 2, 2, 2, 2, 6, 6, 2, 6, 2, 6, 6, 2, 2, 2, 2, 2, 14};
    failures = 0;
    tone     = 16'd1500;
    clear_beacon();
  endfunction

  function void clear_beacon();
    running  = 1'b0;
    position = '0;
    element  = '0;
    lamp     = 1'b0;
    tenths   = '0;
    seconds  = '0;
    cycles   = '0;
    battery  = 7'd100;
    radios   = 1'b0;
  endfunction

  function void set_tone(logic [sos_pkg::ToneW-1:0] hz);
    tone = hz;
  endfunction

  function int outstanding();
    return status_due.size();
  endfunction

  function void advance_pattern(logic [sos_pkg::BattW-1:0] level);
    int unsigned acc;
    bit          hit;
    acc     = 0;
    hit     = 1'b0;
    battery = (level > 7'd100) ? 7'd100 : level;
    tenths  = tenths + 1'b1;
    if (tenths >= 4'd10) begin
      tenths  = '0;
      seconds = seconds + 1'b1;
    end
    position = position + 1'b1;
    for (int i = 0; i < sos_pkg::PatternLen; i++) begin
      acc += ticks_of[i];
      if (!hit && position <= acc) begin
        element = sos_pkg::ElemIdxW'(i);
        lamp    = (i % 2 == 0);  // even elements are marks
        hit     = 1'b1;
      end
    end
    // past the word gap: wrap onto the first tick of the first dot
    if (!hit) begin
      position = 7'd1;
      cycles   = cycles + 1'b1;
      element  = '0;
      lamp     = 1'b1;
    end
  endfunction

  // Applies one accepted word; returns 0 for a tick the block ignores.
  function bit note_word(sos_pkg::op_e op, logic [sos_pkg::BattW-1:0] level);
    sos_pkg::res_t want;
    bit            live;
    live = 1'b1;
    case (op)
      sos_pkg::OP_TICK: begin
        if (running) advance_pattern(level);
        else live = 1'b0;
      end
      sos_pkg::OP_START: begin
        running  = 1'b1;
        radios   = 1'b1;
        position = '0;
        element  = '0;
        lamp     = 1'b0;
        tenths   = '0;
        seconds  = '0;
        cycles   = '0;
      end
      sos_pkg::OP_STOP: begin
        running  = 1'b0;
        lamp     = 1'b0;
        radios   = 1'b0;
        position = '0;
        tenths   = '0;
      end
      default: clear_beacon();
    endcase
    want.light_on         = running & lamp;
    want.tone_hz          = (running & lamp) ? tone : '0;
    want.element_index    = element;
    want.elapsed_seconds  = seconds;
    want.cycle_count      = cycles;
    want.active           = running;
    want.radio_beacons_on = radios;
    want.battery_status   = battery;
    status_due.push_back(want);
    return live;
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_word(logic light, logic [sos_pkg::ToneW-1:0] hz,
                           logic [sos_pkg::ElemIdxW-1:0] elem,
                           logic [sos_pkg::CountW-1:0] secs,
                           logic [sos_pkg::CountW-1:0] cyc, logic act, logic radio,
                           logic [sos_pkg::BattW-1:0] batt);
    sos_pkg::res_t want;
    if (status_due.size() == 0) begin
      failures++;
      $display("%0t ns: status word with none pending, expected nothing, actual elem %0d",
               $time, elem);
      return;
    end
    want = status_due.pop_front();
    compare_field("light_on", want.light_on, light);
    compare_field("tone_hz", want.tone_hz, hz);
    compare_field("element_index", want.element_index, elem);
    compare_field("elapsed_seconds", want.elapsed_seconds, secs);
    compare_field("cycle_count", want.cycle_count, cyc);
    compare_field("active", want.active, act);
    compare_field("radio_beacons_on", want.radio_beacons_on, radio);
    compare_field("battery_status", want.battery_status, batt);
  endfunction
endclass

module sos_morse_beacon_sequencer_top_tb;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [sos_pkg::ToneW-1:0]    cfg_wdata_i     = '0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   operation_i     = sos_pkg::OP_TICK;
  logic [sos_pkg::BattW-1:0]    battery_level_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i     = 1'b0;
  logic                         light_on_o;
  logic [sos_pkg::ToneW-1:0]    tone_hz_o;
  logic [sos_pkg::ElemIdxW-1:0] element_index_o;
  logic [sos_pkg::CountW-1:0]   elapsed_seconds_o;
  logic [sos_pkg::CountW-1:0]   cycle_count_o;
  logic                         active_o;
  logic                         radio_beacons_on_o;
  logic [sos_pkg::BattW-1:0]    battery_status_o;

  beacon_scoreboard sb = new();

  logic calm       = 1'b0;  // no idling on either side once set
  int   gap_pct    = 0;
  int   stall_hold = 0;
  int   live_words = 0;

  sos_morse_beacon_sequencer_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .battery_level_i    (battery_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .light_on_o         (light_on_o),
    .tone_hz_o          (tone_hz_o),
    .element_index_o    (element_index_o),
    .elapsed_seconds_o  (elapsed_seconds_o),
    .cycle_count_o      (cycle_count_o),
    .active_o           (active_o),
    .radio_beacons_on_o (radio_beacons_on_o),
    .battery_status_o   (battery_status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random stall bursts between free-running stretches.
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_hold  <= $urandom_range(0, 17);
    end else begin
      out_stall_i <= 1'b0;
      stall_hold  <= ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                 : $urandom_range(0, 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(light_on_o, tone_hz_o, element_index_o, elapsed_seconds_o,
                    cycle_count_o, active_o, radio_beacons_on_o, battery_status_o);
    end
  end

  function automatic logic [sos_pkg::BattW-1:0] any_level();
    if ($urandom_range(0, 3) == 0) return sos_pkg::BattW'($urandom_range(101, 127));
    return sos_pkg::BattW'($urandom_range(0, 100));
  endfunction

  task automatic send_word(input sos_pkg::op_e op, input logic [sos_pkg::BattW-1:0] level);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    battery_level_i <= level;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sb.note_word(op, level)) live_words++;
  endtask

  // Drop valid and let every pending status word come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_tone(input logic [sos_pkg::ToneW-1:0] hz);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz;
    @(posedge clk_i);
    sb.set_tone(hz);
    cfg_we_i    <= 1'b0;
  endtask

  // Start, a run of ticks with random battery levels, then maybe a stop.
  task automatic run_beacon(input int ticks, input bit with_init);
    if (with_init) send_word(sos_pkg::OP_INIT, any_level());
    send_word(sos_pkg::OP_START, any_level());
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 59) == 0) send_word(sos_pkg::OP_START, any_level());
      send_word(sos_pkg::OP_TICK, any_level());
    end
    if ($urandom_range(0, 1) == 0) begin
      send_word(sos_pkg::OP_STOP, any_level());
      repeat ($urandom_range(0, 3)) send_word(sos_pkg::OP_TICK, any_level());
    end
  endtask

  task automatic run_random(input int target);
    int stop_at;
    int sel;
    stop_at = live_words + target;
    while (live_words < stop_at) begin
      sel = $urandom_range(0, 3);
      gap_pct = (sel < 2) ? 0 : ((sel == 2) ? 8 : 25);
      if ($urandom_range(0, 9) < 7) begin
        run_beacon(($urandom_range(0, 7) == 0) ? $urandom_range(150, 320)
                                               : $urandom_range(1, 150),
                   $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 12))
          send_word(sos_pkg::op_e'($urandom_range(0, 3)), any_level());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset tone.
    send_word(sos_pkg::OP_TICK, 7'd127);   // tick while idle
    send_word(sos_pkg::OP_TICK, 7'd0);
    send_word(sos_pkg::OP_STOP, 7'd0);
    send_word(sos_pkg::OP_START, 7'd127);
    send_word(sos_pkg::OP_TICK, 7'd0);
    send_word(sos_pkg::OP_TICK, 7'd127);   // clamps to full
    send_word(sos_pkg::OP_TICK, 7'd100);
    send_word(sos_pkg::OP_TICK, 7'd101);
    send_word(sos_pkg::OP_TICK, 7'd85);
    send_word(sos_pkg::OP_START, 7'd3);    // restart while running
    send_word(sos_pkg::OP_TICK, 7'd42);
    send_word(sos_pkg::OP_TICK, 7'd7);
    send_word(sos_pkg::OP_TICK, 7'd99);
    send_word(sos_pkg::OP_STOP, 7'd50);
    send_word(sos_pkg::OP_TICK, 7'd127);
    send_word(sos_pkg::OP_START, 7'd0);
    send_word(sos_pkg::OP_TICK, 7'd1);
    send_word(sos_pkg::OP_INIT, 7'd0);
    send_word(sos_pkg::OP_TICK, 7'd64);
    send_word(sos_pkg::OP_START, 7'd127);
    send_word(sos_pkg::OP_TICK, 7'd2);
    send_word(sos_pkg::OP_STOP, 7'd0);
    send_word(sos_pkg::OP_INIT, 7'd127);
    drain();

    write_tone(16'd0);
    run_beacon(150, 1'b0);        // crosses the pattern wrap twice if no restart comes between
    run_random(170);
    drain();

    write_tone(16'hFFFF);
    run_random(320);
    drain();

    write_tone(sos_pkg::ToneW'($urandom_range(0, 65535)));
    run_random(320);
    drain();

    write_tone(16'd1);
    run_random(320);
    drain();

    write_tone(sos_pkg::ToneW'($urandom_range(0, 65535)));
    calm <= 1'b1;
    gap_pct = 0;
    @(posedge clk_i);
    run_random(320);
    drain();

    repeat (4) @(posedge clk_i);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sos_pkg.sv
hw/rtl/sos_morse_beacon_sequencer_top.sv
test/sos_morse_beacon_sequencer_top_tb.sv
